### design/mtu_pkg.sv
// ----------------------------------------------------------------------------
// MT19937 generator package
// Types, constants and the output tempering function shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package mtu_pkg;

	localparam int STATE_WORDS = 624;
	localparam int TAP_OFFSET  = 397;
	localparam int CNT_W       = $clog2(STATE_WORDS);

	localparam logic [31:0] TWIST_CONST  = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
	localparam logic [31:0] SEED_MULT    = 32'd1812433253;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;

	// Request function codes
	localparam logic FUNC_SEED = 1'b0;
	localparam logic FUNC_DRAW = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_BOOT,
		ST_SEED,
		ST_RUN
	} state_t;

	// Controls from the sequencer to the cell chain
	typedef struct packed {
		logic shift;
		logic use_twist;
		logic draw;
	} ctl_t;

	// Standard MT19937 output tempering
	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

### design/mtu_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying a function code and a seed word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtu_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] seed;

	modport source (output valid, output func, output seed, input ready);
	modport sink   (input valid, input func, input seed, output ready);
endinterface

`default_nettype wire

### design/mtu_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one tempered 32-bit word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtu_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### design/mtu_cell.sv
// ----------------------------------------------------------------------------
// State cell
// Holds one 32-bit word of the twister state; loads its neighbor on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mtu_cell (
	input  wire logic        clk,
	input  wire logic        shift,
	input  wire logic [31:0] d,
	output logic [31:0]      q
);

	logic [31:0] word_q;

	// Take the neighbor's word whenever the chain advances
	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

`default_nettype wire

### design/mtu_ctrl.sv
// ----------------------------------------------------------------------------
// Sequencer
// Runs the seeding recurrence into the chain and steers draws.
// ----------------------------------------------------------------------------
`default_nettype none

module mtu_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_func,
	input  wire logic [31:0]   req_seed,
	input  wire logic          out_free,
	input  wire logic [31:0]   last_word,
	output logic               req_ready,
	output mtu_pkg::ctl_t      ctl,
	output logic [31:0]        seed_word
);

	mtu_pkg::state_t               state_q, state_d;
	logic [mtu_pkg::CNT_W-1:0]     cnt_q, cnt_d;
	logic [31:0]                   mix;
	logic [31:0]                   prod;
	logic                          accept;

	// Next seed word from the one just inserted at the chain tail
	assign mix  = last_word ^ (last_word >> 30);
	assign prod = mtu_pkg::SEED_MULT * mix;

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtu_pkg::ST_BOOT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state, chain controls and the word to insert
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		req_ready     = 1'b0;
		ctl.shift     = 1'b0;
		ctl.use_twist = 1'b0;
		ctl.draw      = 1'b0;
		seed_word     = prod + {{(32 - mtu_pkg::CNT_W){1'b0}}, cnt_q};
		unique case (state_q)
			mtu_pkg::ST_BOOT: begin
				ctl.shift = 1'b1;
				seed_word = mtu_pkg::DEFAULT_SEED;
				cnt_d     = mtu_pkg::CNT_W'(1);
				state_d   = mtu_pkg::ST_SEED;
			end
			mtu_pkg::ST_SEED: begin
				ctl.shift = 1'b1;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == mtu_pkg::CNT_W'(mtu_pkg::STATE_WORDS - 1)) begin
					state_d = mtu_pkg::ST_RUN;
				end
			end
			mtu_pkg::ST_RUN: begin
				req_ready = out_free;
				seed_word = req_seed;
				if (accept) begin
					ctl.shift = 1'b1;
					if (req_func == mtu_pkg::FUNC_DRAW) begin
						ctl.use_twist = 1'b1;
						ctl.draw      = 1'b1;
					end else begin
						cnt_d   = mtu_pkg::CNT_W'(1);
						state_d = mtu_pkg::ST_SEED;
					end
				end
			end
			default: begin
				state_d = mtu_pkg::ST_BOOT;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/mersenne_twister_uniform_generator.sv
// ----------------------------------------------------------------------------
// MT19937 uniform generator
// Shift chain of 624 state cells with word-by-word twist and tempering.
// ----------------------------------------------------------------------------
// A draw request (func 1) returns one tempered 32-bit word, a zero word given
// as 1, read as an unsigned 0.32 fraction. Draws are taken one per cycle while
// the output register is empty or its word is taken: each accepted draw twists
// the head of the cell chain, appends the new word at the tail and registers its
// tempered form in the output register. A seed request (func 0) returns nothing
// and holds off requests while the seed enters the chain and 623 steps of the
// initialization recurrence follow, one per cycle through the single 32x32 seed
// multiplier. After reset the same pass runs with seed 5489.
// ----------------------------------------------------------------------------
`default_nettype none

module mersenne_twister_uniform_generator (
	input  wire logic clk,
	input  wire logic arst_n,
	mtu_in_if.sink    req,
	mtu_out_if.source rsp
);

	localparam int N = mtu_pkg::STATE_WORDS;

	logic [31:0]   cell_q [N];
	logic [31:0]   cell_d [N];
	logic [31:0]   ins_word;
	logic [31:0]   seed_word;
	logic [31:0]   twist_y;
	logic [31:0]   twist_word;
	logic [31:0]   tempered;
	mtu_pkg::ctl_t ctl;
	logic          out_free;
	logic          valid_q;
	logic [31:0]   value_q;

	assign out_free = !valid_q || rsp.ready;

	mtu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_seed  (req.seed),
		.out_free  (out_free),
		.last_word (cell_q[N-1]),
		.req_ready (req.ready),
		.ctl       (ctl),
		.seed_word (seed_word)
	);

	// Twist the head of the chain into the next state word
	assign twist_y    = {cell_q[0][31], cell_q[1][30:0]};
	assign twist_word = cell_q[mtu_pkg::TAP_OFFSET] ^ (twist_y >> 1)
		^ (twist_y[0] ? mtu_pkg::TWIST_CONST : 32'h0);
	assign ins_word   = ctl.use_twist ? twist_word : seed_word;
	assign tempered   = mtu_pkg::temper(twist_word);

	// Cell row: each cell takes its right neighbor, the tail takes the new word
	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_cell
			if (k == N - 1) begin : g_tail
				assign cell_d[k] = ins_word;
			end else begin : g_body
				assign cell_d[k] = cell_q[k+1];
			end
			mtu_cell u_cell (
				.clk   (clk),
				.shift (ctl.shift),
				.d     (cell_d[k]),
				.q     (cell_q[k])
			);
		end
	endgenerate

	// Output register: hold until taken, load on a draw
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= ctl.draw;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.draw) begin
			value_q <= (tempered == 32'h0) ? 32'h1 : tempered;
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.value = value_q;

endmodule

`default_nettype wire

### design/mtu_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the request and result channels of the generator over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mtu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        req_func,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rsp_value
);

	logic draw_acc;
	logic seed_acc;

	assign draw_acc = req_valid && req_ready && (req_func == mtu_pkg::FUNC_DRAW);
	assign seed_acc = req_valid && req_ready && (req_func == mtu_pkg::FUNC_SEED);

	// A result word is never zero
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_value != 32'h0))
		else $error("result word is zero");

	// A stalled result holds its word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
		else $error("stalled result changed");

	// An accepted draw shows a result in the next cycle
	a_draw: assert property (@(posedge clk) disable iff (!arst_n)
		draw_acc |=> rsp_valid)
		else $error("draw gave no result");

	// Reseeding blocks further requests
	a_seed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		seed_acc |=> !req_ready)
		else $error("request taken during reseed");

	// A new result appears only after a draw
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(draw_acc))
		else $error("result without a draw");

endmodule

bind mersenne_twister_uniform_generator mtu_checker u_mtu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_func  (req.func),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.value)
);

`default_nettype wire
